### hdl/pdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int REL_W  = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W = 32;
  localparam int TAG_W  = 16;
  localparam int LAT_W  = 16;
  localparam int PCT_W  = 7;
  localparam int KIND_W = 3;
  localparam int EKIND_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_NORMAL  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DUP     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REORDER = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOST    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_LOSS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REORDER = 2'd2;

  localparam logic FUNC_ARRIVAL = 1'b0;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [TIME_W-1:0]  time_v;
    logic [TAG_W-1:0]   tag;
    logic [EKIND_W-1:0] kind;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    idx_t pos;
    idx_t rd_idx;
  } q_ctrl_t;

endpackage

`default_nettype wire

### hdl/pdq_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted entry storage. A push opens a hole at pos by moving every later
// entry up one place; a pop moves every entry down one place.
module pdq_queue (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire pdq_pkg::q_ctrl_t    ctrl,
  input  wire pdq_pkg::entry_t     wdata,
  output pdq_pkg::entry_t          rd_data,
  output pdq_pkg::entry_t          head,
  output pdq_pkg::cnt_t            count
);
  import pdq_pkg::*;

  entry_t ent_r [QUEUE_DEPTH];
  cnt_t   cnt_r;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_ent
    always_ff @(posedge clk) begin
      if (ctrl.push) begin
        if (IDX_W'(i) == ctrl.pos) begin
          ent_r[i] <= wdata;
        end else if (IDX_W'(i) > ctrl.pos) begin
          ent_r[i] <= ent_r[(i > 0) ? i - 1 : 0];
        end
      end else if (ctrl.pop) begin
        ent_r[i] <= ent_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.push) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (ctrl.pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rd_data = ent_r[ctrl.rd_idx];
  assign head    = ent_r[0];
  assign count   = cnt_r;

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.push && ctrl.pop))
    else $error("queue push and pop in the same cycle");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |-> (cnt_r < CNT_W'(QUEUE_DEPTH)))
    else $error("push into a full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> (cnt_r != '0))
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

### hdl/packet_impairment_delay_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Packet impairment delay queue.
// An item is taken when start is high and busy is low. With in_func at 0 it
// is a packet arrival: the packet is lost, or queued (a duplicate first when
// the duplicate draw wins, then the original) in send-time order. With in_func
// at 1 it is a tick that releases every queued entry due at in_now_time, at
// most 16 per tick, oldest send time first.
// Each result shows on the out_ ports for one cycle with out_valid high;
// out_is_last marks the final result of an item. The receiver cannot stall,
// so results are never held back. An arrival whose copies are all queued
// gives no result at all.
// Timing: a lost packet is reported in the cycle after it is taken and busy
// stays low. Each queued copy passes ST_PREP and ST_INS into an empty queue,
// and ST_PREP, ST_TAIL and ST_INS when it lands behind the tail; when it
// overtakes the tail and lands at position p, ST_SCAN also walks entries 0..p
// one per cycle on one 32-bit comparator. A copy that finds the queue full is
// turned away in ST_PREP. A tick makes one comparison of the head per cycle.
// Reset (synchronous, active low) empties the queue and clears all three
// percent registers; no clearing pass is needed. Configuration writes take
// effect at once; making them only while busy is low is left to the user.
module packet_impairment_delay_queue (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire                           in_func,
  input  wire  [pdq_pkg::TAG_W-1:0]     in_packet_tag,
  input  wire  [pdq_pkg::TIME_W-1:0]    in_now_time,
  input  wire  [pdq_pkg::LAT_W-1:0]     in_latency_main,
  input  wire  [pdq_pkg::LAT_W-1:0]     in_latency_copy,
  input  wire  [pdq_pkg::PCT_W-1:0]     in_loss_draw,
  input  wire  [pdq_pkg::PCT_W-1:0]     in_dup_draw,
  input  wire  [pdq_pkg::PCT_W-1:0]     in_reorder_draw_main,
  input  wire  [pdq_pkg::PCT_W-1:0]     in_reorder_draw_copy,
  output logic                          out_valid,
  output logic [pdq_pkg::TAG_W-1:0]     out_tag,
  output logic [pdq_pkg::KIND_W-1:0]    out_kind,
  output logic [pdq_pkg::TIME_W-1:0]    out_time,
  output logic                          out_is_last,
  input  wire                           cfg_we,
  input  wire  [pdq_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire  [pdq_pkg::PCT_W-1:0]     cfg_wdata
);
  import pdq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_TAIL,
    ST_SCAN,
    ST_INS,
    ST_REL
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [PCT_W-1:0] loss_pct_r;
  logic [PCT_W-1:0] dup_pct_r;
  logic [PCT_W-1:0] reorder_pct_r;

  // Captured item fields.
  logic [TAG_W-1:0]  tag_r;
  logic [TIME_W-1:0] now_r;
  logic [LAT_W-1:0]  lat_main_r;
  logic [LAT_W-1:0]  lat_copy_r;
  logic [PCT_W-1:0]  rd_main_r;
  logic [PCT_W-1:0]  rd_copy_r;

  // Working registers for the copy being queued.
  logic                copy_dup_r;
  logic [TIME_W-1:0]   t_r;
  logic [EKIND_W-1:0]  kind_r;
  idx_t                pos_r;
  idx_t                scan_r;

  // Release bookkeeping: a due entry is held in pend_r so that the result
  // can carry out_is_last once the next head proves not to be due.
  logic [REL_W-1:0] rel_r;
  logic             pend_vld_r;
  entry_t           pend_r;

  q_ctrl_t q_ctrl;
  entry_t  q_rd;
  entry_t  q_head;
  cnt_t    q_count;
  cnt_t    cnt_m1;

  logic [TIME_W:0]    sum_w;
  logic [TIME_W-1:0]  sat_time;
  logic [LAT_W-1:0]   cur_lat;
  logic [PCT_W-1:0]   cur_draw;
  logic [TIME_W-1:0]  cmp_a;
  logic [TIME_W-1:0]  cmp_b;
  logic               cmp_lt;
  logic               rel_due;
  logic               q_full;

  // The one shared comparator: copy time against the tail or a scanned
  // entry, or the tick time against the queue head.
  always_comb begin
    if (state_r == ST_REL) begin
      cmp_a = now_r;
      cmp_b = q_head.time_v;
    end else begin
      cmp_a = t_r;
      cmp_b = q_rd.time_v;
    end
  end
  assign cmp_lt = cmp_a < cmp_b;

  assign cur_lat  = copy_dup_r ? lat_copy_r : lat_main_r;
  assign cur_draw = copy_dup_r ? rd_copy_r : rd_main_r;
  assign sum_w    = {1'b0, now_r} + {{(TIME_W + 1 - LAT_W){1'b0}}, cur_lat};
  assign sat_time = sum_w[TIME_W] ? {TIME_W{1'b1}} : sum_w[TIME_W-1:0];

  assign cnt_m1  = q_count - 1'b1;
  assign q_full  = q_count >= CNT_W'(QUEUE_DEPTH);
  assign rel_due = (state_r == ST_REL) && (rel_r < REL_W'(MAX_RESULTS)) &&
                   (q_count != '0) && !cmp_lt;

  always_comb begin
    q_ctrl.push   = (state_r == ST_INS);
    q_ctrl.pop    = rel_due;
    q_ctrl.pos    = pos_r;
    q_ctrl.rd_idx = (state_r == ST_TAIL) ? cnt_m1[IDX_W-1:0] : scan_r;
  end

  pdq_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (q_ctrl),
    .wdata   ({t_r, tag_r, kind_r}),
    .rd_data (q_rd),
    .head    (q_head),
    .count   (q_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loss_pct_r    <= '0;
      dup_pct_r     <= '0;
      reorder_pct_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LOSS:    loss_pct_r    <= cfg_wdata;
        REG_DUP:     dup_pct_r     <= cfg_wdata;
        REG_REORDER: reorder_pct_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid   <= 1'b0;
      out_is_last <= 1'b0;
      pend_vld_r  <= 1'b0;
      copy_dup_r  <= 1'b0;
      rel_r       <= '0;
    end else begin
      out_valid   <= 1'b0;
      out_is_last <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            tag_r      <= in_packet_tag;
            now_r      <= in_now_time;
            lat_main_r <= in_latency_main;
            lat_copy_r <= in_latency_copy;
            rd_main_r  <= in_reorder_draw_main;
            rd_copy_r  <= in_reorder_draw_copy;
            rel_r      <= '0;
            pend_vld_r <= 1'b0;
            if (in_func != FUNC_ARRIVAL) begin
              state_r <= ST_REL;
            end else if (in_loss_draw < loss_pct_r) begin
              out_valid   <= 1'b1;
              out_is_last <= 1'b1;
              out_tag     <= in_packet_tag;
              out_kind    <= KIND_LOST;
              out_time    <= '0;
            end else begin
              copy_dup_r <= in_dup_draw < dup_pct_r;
              state_r    <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          if (q_full) begin
            // A full queue drops this copy; the original is the final one.
            out_valid   <= 1'b1;
            out_is_last <= !copy_dup_r;
            out_tag     <= tag_r;
            out_kind    <= KIND_FULL;
            out_time    <= '0;
            copy_dup_r  <= 1'b0;
            state_r     <= copy_dup_r ? ST_PREP : ST_IDLE;
          end else begin
            t_r    <= sat_time;
            kind_r <= copy_dup_r ? KIND_DUP[EKIND_W-1:0] : KIND_NORMAL[EKIND_W-1:0];
            if (q_count == '0) begin
              pos_r   <= '0;
              state_r <= ST_INS;
            end else begin
              state_r <= ST_TAIL;
            end
          end
        end
        ST_TAIL: begin
          // If the tail is later than this copy, it either overtakes, and then
          // its place is searched, or it waits behind the tail; else it goes behind it.
          if (cmp_lt && (cur_draw < reorder_pct_r)) begin
            kind_r  <= KIND_REORDER[EKIND_W-1:0];
            scan_r  <= '0;
            state_r <= ST_SCAN;
          end else begin
            if (cmp_lt) begin
              t_r <= q_rd.time_v;
            end
            pos_r   <= q_count[IDX_W-1:0];
            state_r <= ST_INS;
          end
        end
        ST_SCAN: begin
          // The tail is known to be later, so the walk always stops.
          if (cmp_lt) begin
            pos_r   <= scan_r;
            state_r <= ST_INS;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        ST_INS: begin
          copy_dup_r <= 1'b0;
          state_r    <= copy_dup_r ? ST_PREP : ST_IDLE;
        end
        ST_REL: begin
          if (pend_vld_r) begin
            out_valid   <= 1'b1;
            out_is_last <= !rel_due;
            out_tag     <= pend_r.tag;
            out_kind    <= {1'b0, pend_r.kind};
            out_time    <= pend_r.time_v;
          end
          if (rel_due) begin
            pend_r     <= q_head;
            pend_vld_r <= 1'b1;
            rel_r      <= rel_r + 1'b1;
          end else begin
            pend_vld_r <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_last) |-> !busy)
    else $error("final result shown while the item is still in work");

  a_drop_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_LOST || out_kind == KIND_FULL)) |->
      (out_time == '0))
    else $error("dropped packet carries a send time");

  a_empty_tick_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REL && q_count == '0) |=> (state_r == ST_IDLE))
    else $error("release continues on an empty queue");

endmodule

`default_nettype wire

### sim/pdq_tb_pkg.sv
`timescale 1ns / 1ps

package pdq_tb_pkg;

  import pdq_pkg::*;

  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic               func;
    logic [TAG_W-1:0]   tag;
    logic [TIME_W-1:0]  now;
    logic [LAT_W-1:0]   lat_main;
    logic [LAT_W-1:0]   lat_copy;
    logic [PCT_W-1:0]   loss_draw;
    logic [PCT_W-1:0]   dup_draw;
    logic [PCT_W-1:0]   rd_main;
    logic [PCT_W-1:0]   rd_copy;
  } pkt_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] time_v;
    logic              last;
  } result_t;

  class delay_queue_scoreboard;

    // Mirror of the send-time ordered queue and of the three percent registers.
    entry_t           sched[$];
    logic [PCT_W-1:0] loss_pct;
    logic [PCT_W-1:0] dup_pct;
    logic [PCT_W-1:0] reorder_pct;
    result_t          due_results[$];

    int unsigned n_items, n_arrivals, n_ticks, n_checked, n_errors;
    int unsigned n_lost, n_full, n_dup, n_reordered;

    function new();
      loss_pct    = '0;
      dup_pct     = '0;
      reorder_pct = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PCT_W-1:0] value);
      case (idx)
        REG_LOSS:    loss_pct = value;
        REG_DUP:     dup_pct = value;
        REG_REORDER: reorder_pct = value;
        default: ;
      endcase
    endfunction

    // Places one copy in the queue; returns 1 with a drop result if it is full.
    function bit place_copy(input logic [TAG_W-1:0] tag, input logic [KIND_W-1:0] kind,
                            input logic [TIME_W-1:0] now, input logic [LAT_W-1:0] lat,
                            input logic [PCT_W-1:0] draw, output result_t drop);
      logic [TIME_W:0]   sum;
      logic [TIME_W-1:0] t;
      int                pos;
      entry_t            e;
      drop = '0;
      if (sched.size() >= QUEUE_DEPTH) begin
        drop = '{tag: tag, kind: KIND_FULL, time_v: '0, last: 1'b0};
        n_full++;
        return 1'b1;
      end
      sum = {1'b0, now} + (TIME_W + 1)'(lat);
      t = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      if (sched.size() > 0 && sched[sched.size()-1].time_v > t) begin
        if (draw < reorder_pct) begin
          kind = KIND_REORDER;
          n_reordered++;
        end else begin
          t = sched[sched.size()-1].time_v;
        end
      end
      pos = sched.size();
      for (int i = 0; i < sched.size(); i++) begin
        if (t < sched[i].time_v) begin
          pos = i;
          break;
        end
      end
      e.time_v = t;
      e.tag    = tag;
      e.kind   = kind[EKIND_W-1:0];
      sched.insert(pos, e);
      return 1'b0;
    endfunction

    function void note_item(pkt_item_t it);
      result_t batch[$];
      result_t r;
      n_items++;
      if (it.func == FUNC_ARRIVAL) begin
        n_arrivals++;
        if (it.loss_draw < loss_pct) begin
          batch.push_back('{tag: it.tag, kind: KIND_LOST, time_v: '0, last: 1'b0});
          n_lost++;
        end else begin
          if (it.dup_draw < dup_pct) begin
            n_dup++;
            if (place_copy(it.tag, KIND_DUP, it.now, it.lat_copy, it.rd_copy, r))
              batch.push_back(r);
          end
          if (place_copy(it.tag, KIND_NORMAL, it.now, it.lat_main, it.rd_main, r))
            batch.push_back(r);
        end
      end else begin
        n_ticks++;
        while (batch.size() < MAX_RESULTS && sched.size() > 0 && sched[0].time_v <= it.now) begin
          r = '{tag: sched[0].tag, kind: KIND_W'(sched[0].kind), time_v: sched[0].time_v,
                last: 1'b0};
          batch.push_back(r);
          sched.delete(0);
        end
      end
      if (batch.size() > 0)
        batch[batch.size()-1].last = 1'b1;
      foreach (batch[i])
        due_results.push_back(batch[i]);
    endfunction

    function void flag(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      n_errors++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tag %0h kind %0d time %0h last %0b",
                 $time, got.tag, got.kind, got.time_v, got.last);
        n_errors++;
        return;
      end
      want = due_results[0];
      due_results.delete(0);
      n_checked++;
      if (got.tag !== want.tag)       flag("out_tag", TIME_W'(want.tag), TIME_W'(got.tag));
      if (got.kind !== want.kind)     flag("out_kind", TIME_W'(want.kind), TIME_W'(got.kind));
      if (got.time_v !== want.time_v) flag("out_time", want.time_v, got.time_v);
      if (got.last !== want.last)     flag("out_is_last", TIME_W'(want.last), TIME_W'(got.last));
    endfunction

    function int pending();
      return due_results.size();
    endfunction

  endclass

endpackage

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import pdq_pkg::*;
  import pdq_tb_pkg::*;

  // The longest quiet stretch in a correct run is the settling pause between
  // phases plus one arrival whose two copies both walk the whole queue. The
  // watchdog allows many times that.
  localparam int IDLE_LIMIT    = 2000;
  // An arrival whose copies are all queued gives no result, so after the last
  // result the block may still be sorting.
  localparam int SETTLE_CYCLES = 48;
  localparam int PHASE_ITEMS   = 52;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  pkt_item_t drive_pkt = '0;

  logic                  out_valid;
  logic [TAG_W-1:0]      out_tag;
  logic [KIND_W-1:0]     out_kind;
  logic [TIME_W-1:0]     out_time;
  logic                  out_is_last;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_LOSS;
  logic [PCT_W-1:0]      cfg_wdata = '0;

  // Percent of cycles in which the sender holds start low before an item.
  int sender_gap_pct = 0;
  // Running millisecond clock that the well-formed stimulus follows.
  logic [TIME_W-1:0] clock_ms = '0;
  int quiet_cycles = 0;

  delay_queue_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  packet_impairment_delay_queue dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_func              (drive_pkt.func),
    .in_packet_tag        (drive_pkt.tag),
    .in_now_time          (drive_pkt.now),
    .in_latency_main      (drive_pkt.lat_main),
    .in_latency_copy      (drive_pkt.lat_copy),
    .in_loss_draw         (drive_pkt.loss_draw),
    .in_dup_draw          (drive_pkt.dup_draw),
    .in_reorder_draw_main (drive_pkt.rd_main),
    .in_reorder_draw_copy (drive_pkt.rd_copy),
    .out_valid            (out_valid),
    .out_tag              (out_tag),
    .out_kind             (out_kind),
    .out_time             (out_time),
    .out_is_last          (out_is_last),
    .cfg_we               (cfg_we),
    .cfg_idx              (cfg_idx),
    .cfg_wdata            (cfg_wdata)
  );

  // Monitor. All inputs change only through nonblocking assignments at the
  // rising edge, so the values read here are the ones the block samples at
  // this edge. A result present now always belongs to an earlier item, so it
  // is checked before the item accepted at this same edge is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result('{tag: out_tag, kind: out_kind, time_v: out_time, last: out_is_last});
      if (cfg_we)
        sb.write_reg(cfg_idx, cfg_wdata);
      if (start && !busy)
        sb.note_item(drive_pkt);
      if (out_valid || cfg_we || (start && !busy))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time, sb.pending());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic pkt_item_t arrival(logic [TAG_W-1:0] tag, logic [TIME_W-1:0] now,
                                        logic [LAT_W-1:0] lm, logic [LAT_W-1:0] lc,
                                        logic [PCT_W-1:0] ld, logic [PCT_W-1:0] dd,
                                        logic [PCT_W-1:0] rm, logic [PCT_W-1:0] rc);
    pkt_item_t p;
    p = '{func: FUNC_ARRIVAL, tag: tag, now: now, lat_main: lm, lat_copy: lc,
          loss_draw: ld, dup_draw: dd, rd_main: rm, rd_copy: rc};
    return p;
  endfunction

  function automatic pkt_item_t tick_at(logic [TIME_W-1:0] now);
    pkt_item_t p;
    p = '0;
    p.func = FUNC_TICK;
    p.now  = now;
    return p;
  endfunction

  // Mostly short delays so that ticks release often; now and then a long one
  // that holds the tail back and forces later packets to be raised or reordered.
  function automatic logic [LAT_W-1:0] pick_latency();
    return ($urandom_range(15) == 0) ? LAT_W'($urandom) : LAT_W'($urandom_range(63));
  endfunction

  // Draws normally stay in 0..99; a few land above to exercise the raw compare.
  function automatic logic [PCT_W-1:0] pick_draw();
    return ($urandom_range(7) == 0) ? PCT_W'($urandom_range(127, 100)) :
                                      PCT_W'($urandom_range(99));
  endfunction

  // Before presenting an item the sender may rest: each cycle it idles with
  // the chance set by sender_gap_pct. The item is then held until taken.
  task automatic send_pkt(input pkt_item_t p);
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    drive_pkt <= p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Brings the block to rest: every predicted result has come back and any
  // arrival that gives no result has had time to finish its sorted insert.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Writes all three percent registers on back-to-back cycles.
  task automatic program_percents(input logic [PCT_W-1:0] loss, input logic [PCT_W-1:0] dup,
                                  input logic [PCT_W-1:0] reorder);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_LOSS;
    cfg_wdata <= loss;
    @(posedge clk);
    cfg_idx   <= REG_DUP;
    cfg_wdata <= dup;
    @(posedge clk);
    cfg_idx   <= REG_REORDER;
    cfg_wdata <= reorder;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random traffic: bursts of arrivals at the running clock, each closed by a
  // tick a little later, with about one item in ten fully random as noise.
  task automatic run_random(input int count);
    pkt_item_t p;
    int burst;
    burst = $urandom_range(1, 10);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) begin
        p.func      = 1'($urandom_range(1));
        p.tag       = TAG_W'($urandom);
        p.now       = TIME_W'($urandom);
        p.lat_main  = LAT_W'($urandom);
        p.lat_copy  = LAT_W'($urandom);
        p.loss_draw = PCT_W'($urandom_range(127));
        p.dup_draw  = PCT_W'($urandom_range(127));
        p.rd_main   = PCT_W'($urandom_range(127));
        p.rd_copy   = PCT_W'($urandom_range(127));
      end else if (burst > 0) begin
        p = arrival(TAG_W'($urandom), clock_ms, pick_latency(), pick_latency(),
                    pick_draw(), pick_draw(), pick_draw(), pick_draw());
        clock_ms += TIME_W'($urandom_range(8));
        burst--;
      end else begin
        // Usually a small step in time; sometimes a jump past the long delays.
        clock_ms += ($urandom_range(5) == 0) ? TIME_W'($urandom_range(70000)) :
                                               TIME_W'($urandom_range(64));
        p = tick_at(clock_ms);
        burst = $urandom_range(1, 10);
      end
      send_pkt(p);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    sender_gap_pct = 34;

    // Every arrival is duplicated, and an overtaking copy is reordered when
    // its draw is below one half.
    program_percents(7'd0, 7'd100, 7'd50);
    send_pkt(tick_at('0));                        // tick on an empty queue
    send_pkt(arrival(16'h0000, '0, '0, '0, 7'd0, 7'd0, 7'd0, 7'd0));
    // Send time saturates at the top of the range; the duplicate draw of 127
    // loses against a percent of 100.
    send_pkt(arrival(16'hFFFF, 32'hFFFF_FFF0, 16'hFFFF, 16'h0001,
                     7'd127, 7'd127, 7'd127, 7'd127));
    // The duplicate overtakes the saturated tail and is reordered; the
    // original loses its draw and is raised to the tail's time.
    send_pkt(arrival(16'h1111, 32'd10, 16'd5, 16'd3, 7'd99, 7'd0, 7'd99, 7'd0));
    send_pkt(tick_at(32'd12));
    send_pkt(tick_at(32'hFFFF_FFFE));
    send_pkt(tick_at('1));
    wait_idle();

    // Loss at exactly 100 percent, then above the normal range at 127.
    program_percents(7'd100, 7'd0, 7'd0);
    send_pkt(arrival(16'hA5A5, 32'd500, 16'd20, 16'd0, 7'd99, 7'd0, 7'd0, 7'd0));
    send_pkt(arrival(16'h5A5A, 32'd500, 16'd20, 16'd0, 7'd100, 7'd0, 7'd0, 7'd0));
    wait_idle();
    program_percents(7'd127, 7'd0, 7'd0);
    send_pkt(arrival(16'h0F0F, 32'd600, 16'd1, 16'd0, 7'd126, 7'd0, 7'd0, 7'd0));
    send_pkt(arrival(16'hF0F0, 32'd600, 16'd1, 16'd0, 7'd127, 7'd0, 7'd0, 7'd0));
    send_pkt(tick_at('1));
    wait_idle();

    // Fill the queue. Later arrivals carry shorter delays so each copy
    // overtakes the tail and walks the queue. The first arrival is not
    // duplicated, so the ninth finds one free slot: its duplicate goes in and
    // its original is turned away. The tenth loses both copies.
    program_percents(7'd0, 7'd127, 7'd127);
    send_pkt(arrival(16'h0100, 32'd1000, 16'd500, 16'd300, 7'd0, 7'd127, 7'd0, 7'd0));
    for (int i = 1; i < 10; i++)
      send_pkt(arrival(TAG_W'(16'h0100 + i), TIME_W'(1000 + i), LAT_W'(500 - 40 * i),
                       LAT_W'(300 - 20 * i), 7'd0, 7'd126, 7'd0, 7'd64));
    // A full queue that is all due goes out in one tick of sixteen results.
    send_pkt(tick_at('1));
    wait_idle();

    program_percents(7'd15, 7'd40, 7'd30);
    clock_ms = TIME_W'($urandom_range(100000));
    run_random(PHASE_ITEMS);
    wait_idle();

    sender_gap_pct = 63;
    program_percents(7'd5, 7'd80, 7'd60);
    run_random(PHASE_ITEMS);
    wait_idle();

    // Last phase runs near the top of the time range so sums saturate and
    // the running clock wraps.
    sender_gap_pct = 0;
    program_percents(7'd25, 7'd20, 7'd0);
    clock_ms = 32'hFFFF_0000;
    run_random(PHASE_ITEMS);
    send_pkt(tick_at('1));
    wait_idle();

    $display("Run covered %0d items: %0d arrivals and %0d ticks, %0d results checked.",
             sb.n_items, sb.n_arrivals, sb.n_ticks, sb.n_checked);
    $display("Packets lost %0d, duplicated %0d, reordered %0d, turned away when full %0d.",
             sb.n_lost, sb.n_dup, sb.n_reordered, sb.n_full);
    if (sb.n_errors == 0 && sb.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
